// ===== hdl/pva_pkg.sv =====
// Shared types, codes and sizes of the polyphonic voice allocator.
package pva_pkg;

    localparam int VOICES    = 16;
    localparam int TIME_BITS = 32;
    localparam int IDX_W     = 4;
    localparam int CNT_W     = IDX_W + 1;
    localparam int MASK_W    = 16;
    localparam int KEY_W     = TIME_BITS;
    localparam int REG_IDX_W = 1;
    localparam int REG_W     = 5;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_VOICE_LIMIT = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEAL_RULE  = 1'd1;

    // Event opcodes
    localparam logic [2:0] OP_NOTE_ON   = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF  = 3'd1;
    localparam logic [2:0] OP_REL_ALL   = 3'd2;
    localparam logic [2:0] OP_LEVEL     = 3'd3;
    localparam logic [2:0] OP_FINISH    = 3'd4;
    localparam logic [2:0] OP_ADVANCE   = 3'd5;

    // Steal rules
    localparam logic [1:0] STEAL_OLDEST   = 2'd0;
    localparam logic [1:0] STEAL_QUIETEST = 2'd1;
    localparam logic [1:0] STEAL_LOWEST   = 2'd2;
    localparam logic [1:0] STEAL_HIGHEST  = 2'd3;

    // Voice status
    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_ACTIVE    = 2'd1;
    localparam logic [1:0] ST_RELEASING = 2'd2;

    // Commands broadcast to the cells
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_TRIGGER  = 3'd1;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd2;
    localparam logic [2:0] CMD_REL_ALL  = 3'd3;
    localparam logic [2:0] CMD_LEVEL    = 3'd4;
    localparam logic [2:0] CMD_FINISH   = 3'd5;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [3:0]  channel;
        logic [3:0]  voice_sel;
        logic [15:0] level;
        logic [15:0] frames;
    } request_t;

    typedef struct packed {
        logic [3:0]        voice_index;
        logic              stole;
        logic              legato;
        logic [MASK_W-1:0] changed_mask;
        logic [MASK_W-1:0] active_mask;
    } result_t;

    // Search token that walks down the chain of voice cells
    typedef struct packed {
        logic             valid;
        logic             idle_found;
        logic [IDX_W-1:0] idle_idx;
        logic             have_best;
        logic [IDX_W-1:0] best_idx;
        logic [KEY_W-1:0] best_key;
    } scan_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [IDX_W-1:0]     idx;
        logic [6:0]           note;
        logic [6:0]           velocity;
        logic [3:0]           channel;
        logic [15:0]          level;
        logic [TIME_BITS-1:0] now;
        logic                 mono;
    } cmd_t;

    typedef struct packed {
        logic sounding;
        logic changed;
        logic legato;
    } cell_flags_t;

endpackage

// ===== hdl/pva_cell.sv =====
// One voice cell: voice state, command decode and one search step of the chain.
module pva_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pva_pkg::IDX_W-1:0] my_idx,
    input  logic                      in_use,
    input  logic [1:0]                steal_rule,
    input  pva_pkg::cmd_t             cmd,
    input  pva_pkg::scan_t            scan_in,
    output pva_pkg::scan_t            scan_out,
    output pva_pkg::cell_flags_t      flags
);

    logic [1:0]                    status_reg, status_next;
    logic [6:0]                    note_reg;
    logic [3:0]                    channel_reg;
    logic [6:0]                    velocity_reg;
    logic [pva_pkg::TIME_BITS-1:0] start_reg;
    logic [15:0]                   level_reg;
    logic                          changed_reg, changed_next;
    logic                          legato_reg, legato_next;
    pva_pkg::scan_t                scan_reg, scan_next;
    logic [pva_pkg::KEY_W-1:0]     key;
    logic                          hit;
    logic                          keep_pitch;

    assign hit        = (cmd.idx == my_idx);
    assign keep_pitch = cmd.mono && (status_reg == pva_pkg::ST_ACTIVE);

    // Steal key: smaller wins
    always_comb
    begin
        unique case (steal_rule)
            pva_pkg::STEAL_OLDEST:   key = start_reg;
            pva_pkg::STEAL_QUIETEST: key = pva_pkg::KEY_W'(level_reg);
            pva_pkg::STEAL_LOWEST:   key = pva_pkg::KEY_W'(note_reg);
            default:                 key = pva_pkg::KEY_W'(~note_reg);
        endcase
    end

    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.valid && in_use)
        begin
            if (status_reg == pva_pkg::ST_IDLE && !scan_in.idle_found)
            begin
                scan_next.idle_found = 1'b1;
                scan_next.idle_idx   = my_idx;
            end
            if (!scan_in.have_best || key < scan_in.best_key)
            begin
                scan_next.have_best = 1'b1;
                scan_next.best_idx  = my_idx;
                scan_next.best_key  = key;
            end
        end
    end

    always_comb
    begin
        status_next  = status_reg;
        changed_next = 1'b0;
        legato_next  = 1'b0;
        unique case (cmd.kind)
            pva_pkg::CMD_TRIGGER:
            begin
                if (hit)
                begin
                    changed_next = 1'b1;
                    legato_next  = keep_pitch;
                    status_next  = pva_pkg::ST_ACTIVE;
                end
            end
            pva_pkg::CMD_NOTE_OFF:
            begin
                if (status_reg == pva_pkg::ST_ACTIVE && note_reg == cmd.note &&
                    channel_reg == cmd.channel)
                begin
                    status_next  = pva_pkg::ST_RELEASING;
                    changed_next = 1'b1;
                end
            end
            pva_pkg::CMD_REL_ALL:
            begin
                if (status_reg == pva_pkg::ST_ACTIVE)
                begin
                    status_next  = pva_pkg::ST_RELEASING;
                    changed_next = 1'b1;
                end
            end
            pva_pkg::CMD_FINISH:
            begin
                if (hit && status_reg != pva_pkg::ST_IDLE)
                begin
                    status_next  = pva_pkg::ST_IDLE;
                    changed_next = 1'b1;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= pva_pkg::ST_IDLE;
            changed_reg <= 1'b0;
            legato_reg  <= 1'b0;
            scan_reg    <= '0;
        end
        else
        begin
            status_reg  <= status_next;
            changed_reg <= changed_next;
            legato_reg  <= legato_next;
            scan_reg    <= scan_next;
        end
    end

    // Voice payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_reg     <= '0;
            velocity_reg <= '0;
            channel_reg  <= '0;
            start_reg    <= '0;
            level_reg    <= '0;
        end
        else if (cmd.kind == pva_pkg::CMD_TRIGGER && hit)
        begin
            note_reg     <= cmd.note;
            velocity_reg <= cmd.velocity;
            if (!keep_pitch)
            begin
                channel_reg <= cmd.channel;
                start_reg   <= cmd.now;
                level_reg   <= '0;
            end
        end
        else if (cmd.kind == pva_pkg::CMD_LEVEL && hit)
        begin
            level_reg <= cmd.level;
        end
    end

    assign scan_out       = scan_reg;
    assign flags.sounding = (status_reg != pva_pkg::ST_IDLE);
    assign flags.changed  = changed_reg;
    assign flags.legato   = legato_reg;

endmodule

// ===== hdl/poly_voice_allocator.sv =====
// Top level of the polyphonic voice allocator: event sequencer and chain of voice cells.
//
// Usage:
//   Events enter on request, taken at a clock edge where start is high and busy
//   is low. One result beat follows each event on result, marked by done for
//   exactly one cycle; the receiver cannot stall it, so capture it when done is
//   high. The user writes the voice limit (index 0) and the steal rule (index 1) through
//   wr_en / wr_index / wr_data while the block is idle; the block does not enforce it.
//
// Event flow:
//   Note-on walks a search token down the row of VOICES cells, one cell per
//   cycle, then commits and reports. Every other event passes through the
//   apply state, where its command reaches the cells, then the report state.
//   busy drops in the cycle done is high, so the next event is taken at the
//   edge that ends it. The voice chain's search length sets the rate.
//
// Reset:
//   All voices idle, time counter zero, voice limit 16, steal rule oldest.
//   No clearing pass is needed; the block takes events right after reset.
module poly_voice_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pva_pkg::request_t             request,
    output logic                          done,
    output pva_pkg::result_t              result,
    input  logic                          wr_en,
    input  logic [pva_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [pva_pkg::REG_W-1:0]     wr_data
);

    localparam int VN = pva_pkg::VOICES;
    localparam int MW = pva_pkg::MASK_W;
    localparam int TW = pva_pkg::TIME_BITS;
    localparam int CW = pva_pkg::CNT_W;
    localparam int IW = pva_pkg::IDX_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_APPLY  = 2'd2;
    localparam logic [1:0] S_REPORT = 2'd3;

    logic [1:0]            state_reg, state_next;
    pva_pkg::request_t     item_reg;
    logic                  launch_reg;
    logic [4:0]            voice_limit_reg;
    logic [1:0]            steal_rule_reg;
    logic [TW-1:0]         time_reg, time_next;
    logic [IW-1:0]         pick_reg;
    logic                  stole_reg;
    logic                  done_reg;
    pva_pkg::result_t      result_reg, result_next;
    logic [CW-1:0]         n_voices;
    logic [TW:0]           time_sum;
    logic                  accept;
    logic                  scan_end;
    logic [IW-1:0]         pick;
    pva_pkg::cmd_t         cmd;
    pva_pkg::scan_t        chain [VN+1];
    pva_pkg::cell_flags_t  flags [VN];
    logic [VN-1:0]         in_use;
    logic [VN-1:0]         changed_vec;
    logic [VN-1:0]         active_vec;
    logic [VN-1:0]         legato_vec;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // Clamp the voice count to 1..VOICES
    always_comb
    begin
        priority if (voice_limit_reg == '0)
            n_voices = CW'(1);
        else if (voice_limit_reg > 5'(VN))
            n_voices = CW'(VN);
        else
            n_voices = CW'(voice_limit_reg);
    end

    // Launch token: empty candidate, valid for one cycle
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = launch_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < VN; gi++)
        begin : g_cell
            assign in_use[gi]      = (CW'(gi) < n_voices);
            assign changed_vec[gi] = flags[gi].changed;
            assign active_vec[gi]  = flags[gi].sounding;
            assign legato_vec[gi]  = flags[gi].legato;

            pva_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .my_idx     (IW'(gi)),
                .in_use     (in_use[gi]),
                .steal_rule (steal_rule_reg),
                .cmd        (cmd),
                .scan_in    (chain[gi]),
                .scan_out   (chain[gi+1]),
                .flags      (flags[gi])
            );
        end
    endgenerate

    assign scan_end = (state_reg == S_SCAN) && chain[VN].valid;
    assign pick     = chain[VN].idle_found ? chain[VN].idle_idx : chain[VN].best_idx;

    // Broadcast command to the cells
    always_comb
    begin
        cmd          = '0;
        cmd.kind     = pva_pkg::CMD_NONE;
        cmd.note     = item_reg.note;
        cmd.velocity = item_reg.velocity;
        cmd.channel  = item_reg.channel;
        cmd.level    = item_reg.level;
        cmd.now      = time_reg;
        cmd.mono     = (n_voices == CW'(1));
        cmd.idx      = item_reg.voice_sel;
        if (scan_end)
        begin
            cmd.kind = pva_pkg::CMD_TRIGGER;
            cmd.idx  = pick;
        end
        else if (state_reg == S_APPLY)
        begin
            unique case (item_reg.opcode)
                pva_pkg::OP_NOTE_OFF: cmd.kind = pva_pkg::CMD_NOTE_OFF;
                pva_pkg::OP_REL_ALL:  cmd.kind = pva_pkg::CMD_REL_ALL;
                pva_pkg::OP_LEVEL:    cmd.kind = pva_pkg::CMD_LEVEL;
                pva_pkg::OP_FINISH:   cmd.kind = pva_pkg::CMD_FINISH;
                default:              cmd.kind = pva_pkg::CMD_NONE;
            endcase
        end
    end

    // Saturating sample counter
    assign time_sum = {1'b0, time_reg} + (TW+1)'(item_reg.frames);

    always_comb
    begin
        time_next = time_reg;
        if (state_reg == S_APPLY && item_reg.opcode == pva_pkg::OP_ADVANCE)
        begin
            time_next = time_sum[TW] ? '1 : time_sum[TW-1:0];
        end
    end

    // Sequencer: accept, search, apply, report
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (request.opcode == pva_pkg::OP_NOTE_ON) ? S_SCAN : S_APPLY;
            end
            S_SCAN:
            begin
                if (scan_end)
                    state_next = S_REPORT;
            end
            S_APPLY:  state_next = S_REPORT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Report reads the cells after the commit edge
    always_comb
    begin
        result_next              = '0;
        result_next.changed_mask = MW'(changed_vec);
        result_next.active_mask  = MW'(active_vec);
        result_next.legato       = |legato_vec;
        if (item_reg.opcode == pva_pkg::OP_NOTE_ON)
        begin
            result_next.voice_index = pick_reg;
            result_next.stole       = stole_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            launch_reg      <= 1'b0;
            done_reg        <= 1'b0;
            voice_limit_reg <= 5'd16;
            steal_rule_reg  <= pva_pkg::STEAL_OLDEST;
            time_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept && (request.opcode == pva_pkg::OP_NOTE_ON);
            done_reg   <= (state_reg == S_REPORT);
            time_reg   <= time_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    pva_pkg::REG_VOICE_LIMIT: voice_limit_reg <= wr_data;
                    pva_pkg::REG_STEAL_RULE:  steal_rule_reg  <= wr_data[1:0];
                endcase
            end
        end
    end

    // Payload: hold the event, the pick and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= request;
        if (scan_end)
        begin
            pick_reg  <= pick;
            stole_reg <= !chain[VN].idle_found;
        end
        if (state_reg == S_REPORT)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_REPORT)
        else $error("done without a report cycle");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[VN].valid |-> state_reg == S_SCAN)
        else $error("search token left the chain outside a scan");

    a_note_on_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPORT && item_reg.opcode == pva_pkg::OP_NOTE_ON)
        |-> $onehot(changed_vec) && active_vec[pick_reg])
        else $error("note on did not trigger exactly the picked voice");

    a_legato_steals: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.legato) |-> result.stole && result.voice_index == '0)
        else $error("legato without taking voice zero");
`endif

endmodule

// ===== tb/poly_voice_allocator_test.sv =====
// Self-checking testbench for the polyphonic voice allocator.
module poly_voice_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Opcodes the block does not define; they must leave the voice table alone
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int DRAIN_CYCLES  = 100;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int RANDOM_EVENTS = 1600;
    localparam int PHASES        = 12;
    localparam logic [pva_pkg::TIME_BITS-1:0] TIME_MAX = '1;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          start    = 1'b0;
    logic                          busy;
    pva_pkg::request_t             request  = '0;
    logic                          done;
    pva_pkg::result_t              result;
    logic                          wr_en    = 1'b0;
    logic [pva_pkg::REG_IDX_W-1:0] wr_index = '0;
    logic [pva_pkg::REG_W-1:0]     wr_data  = '0;

    poly_voice_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow voice table: our own copy of every voice, the sample counter
    // and both registers, advanced once per accepted event.
    // ------------------------------------------------------------------
    logic [1:0]                    tbl_status   [pva_pkg::VOICES];
    logic [6:0]                    tbl_note     [pva_pkg::VOICES];
    logic [3:0]                    tbl_channel  [pva_pkg::VOICES];
    logic [6:0]                    tbl_velocity [pva_pkg::VOICES];
    logic [pva_pkg::TIME_BITS-1:0] tbl_start    [pva_pkg::VOICES];
    logic [15:0]                   tbl_level    [pva_pkg::VOICES];
    logic [pva_pkg::TIME_BITS-1:0] sample_count;
    logic [pva_pkg::REG_W-1:0]     voices_in_use;
    logic [1:0]                    steal_rule;

    // Result beats owed by the block, oldest first
    pva_pkg::result_t pending_reports[$];

    int fail_count      = 0;
    int events_sent     = 0;
    int reports_checked = 0;
    int reg_writes      = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 0;

    function automatic void clear_voice_table();
        for (int i = 0; i < pva_pkg::VOICES; i++)
        begin
            tbl_status[i]   = pva_pkg::ST_IDLE;
            tbl_note[i]     = '0;
            tbl_channel[i]  = '0;
            tbl_velocity[i] = '0;
            tbl_start[i]    = '0;
            tbl_level[i]    = '0;
        end
        sample_count  = '0;
        voices_in_use = 5'd16;
        steal_rule    = pva_pkg::STEAL_OLDEST;
    endfunction

    // Scan the voices in use for the one to steal; a tie keeps the lower index.
    function automatic int choose_victim(int n);
        int   best;
        logic better;
        best = 0;
        for (int i = 1; i < n; i++)
        begin
            case (steal_rule)
                pva_pkg::STEAL_OLDEST:   better = tbl_start[i] < tbl_start[best];
                pva_pkg::STEAL_QUIETEST: better = tbl_level[i] < tbl_level[best];
                pva_pkg::STEAL_LOWEST:   better = tbl_note[i] < tbl_note[best];
                default:                 better = tbl_note[i] > tbl_note[best];
            endcase
            if (better)
                best = i;
        end
        return best;
    endfunction

    // Apply one event to the shadow table and return the beat it must produce.
    function automatic pva_pkg::result_t allocate_event(pva_pkg::request_t ev);
        pva_pkg::result_t              rep;
        int                            n;
        int                            idx;
        logic                          found;
        logic [pva_pkg::TIME_BITS:0]   sum;
        rep = '0;
        n   = voices_in_use;
        // Out-of-range voice counts clamp; mono is judged on the clamped count
        if (n < 1)
            n = 1;
        if (n > pva_pkg::VOICES)
            n = pva_pkg::VOICES;
        case (ev.opcode)
            pva_pkg::OP_NOTE_ON:
            begin
                found = 1'b0;
                idx   = 0;
                for (int i = 0; i < n; i++)
                begin
                    if (!found && tbl_status[i] == pva_pkg::ST_IDLE)
                    begin
                        idx   = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    idx       = choose_victim(n);
                    rep.stole = 1'b1;
                end
                if (n == 1 && tbl_status[idx] == pva_pkg::ST_ACTIVE)
                begin
                    // Legato: only pitch and velocity move
                    tbl_note[idx]     = ev.note;
                    tbl_velocity[idx] = ev.velocity;
                    rep.legato        = 1'b1;
                end
                else
                begin
                    tbl_status[idx]   = pva_pkg::ST_ACTIVE;
                    tbl_note[idx]     = ev.note;
                    tbl_channel[idx]  = ev.channel;
                    tbl_velocity[idx] = ev.velocity;
                    tbl_start[idx]    = sample_count;
                    tbl_level[idx]    = '0;
                end
                rep.voice_index       = idx[pva_pkg::IDX_W-1:0];
                rep.changed_mask[idx] = 1'b1;
            end
            pva_pkg::OP_NOTE_OFF:
            begin
                // Every voice is searched, not only those in use
                for (int i = 0; i < pva_pkg::VOICES; i++)
                begin
                    if (tbl_status[i] == pva_pkg::ST_ACTIVE && tbl_note[i] == ev.note &&
                        tbl_channel[i] == ev.channel)
                    begin
                        tbl_status[i]       = pva_pkg::ST_RELEASING;
                        rep.changed_mask[i] = 1'b1;
                    end
                end
            end
            pva_pkg::OP_REL_ALL:
            begin
                for (int i = 0; i < pva_pkg::VOICES; i++)
                begin
                    if (tbl_status[i] == pva_pkg::ST_ACTIVE)
                    begin
                        tbl_status[i]       = pva_pkg::ST_RELEASING;
                        rep.changed_mask[i] = 1'b1;
                    end
                end
            end
            pva_pkg::OP_LEVEL:
            begin
                if (int'(ev.voice_sel) < pva_pkg::VOICES)
                    tbl_level[ev.voice_sel] = ev.level;
            end
            pva_pkg::OP_FINISH:
            begin
                if (int'(ev.voice_sel) < pva_pkg::VOICES &&
                    tbl_status[ev.voice_sel] != pva_pkg::ST_IDLE)
                begin
                    tbl_status[ev.voice_sel]       = pva_pkg::ST_IDLE;
                    rep.changed_mask[ev.voice_sel] = 1'b1;
                end
            end
            pva_pkg::OP_ADVANCE:
            begin
                // Saturate rather than wrap
                sum          = {1'b0, sample_count} + ev.frames;
                sample_count = sum[pva_pkg::TIME_BITS] ? TIME_MAX
                                                       : sum[pva_pkg::TIME_BITS-1:0];
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < pva_pkg::VOICES; i++)
            rep.active_mask[i] = (tbl_status[i] != pva_pkg::ST_IDLE);
        return rep;
    endfunction

    function automatic pva_pkg::request_t make_event(logic [2:0] op, logic [6:0] note,
                                                     logic [6:0] vel, logic [3:0] ch,
                                                     logic [3:0] sel, logic [15:0] lvl,
                                                     logic [15:0] frames);
        pva_pkg::request_t ev;
        ev.opcode    = op;
        ev.note      = note;
        ev.velocity  = vel;
        ev.channel   = ch;
        ev.voice_sel = sel;
        ev.level     = lvl;
        ev.frames    = frames;
        return ev;
    endfunction

    // Random voice in the given status, or -1 when there is none.
    function automatic int pick_voice(logic [1:0] status);
        int hits[$];
        for (int i = 0; i < pva_pkg::VOICES; i++)
        begin
            if (tbl_status[i] == status)
                hits.push_back(i);
        end
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(0, hits.size() - 1)];
    endfunction

    // Mostly well-formed traffic: note-offs aim at sounding notes, finishes at
    // releasing voices, level updates at active ones. A small share is noise.
    function automatic pva_pkg::request_t random_event();
        pva_pkg::request_t ev;
        int                pick;
        int                v;
        ev.opcode    = pva_pkg::OP_NOTE_ON;
        ev.note      = 7'($urandom_range(0, 127));
        ev.velocity  = 7'($urandom_range(0, 127));
        ev.channel   = 4'($urandom_range(0, 15));
        ev.voice_sel = 4'($urandom_range(0, 15));
        ev.level     = 16'($urandom());
        ev.frames    = 16'($urandom());
        // Crowd a few pitches and channels so ties and double matches occur
        if ($urandom_range(0, 3) == 0)
        begin
            ev.note    = 7'($urandom_range(60, 63));
            ev.channel = 4'($urandom_range(0, 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)
            ev.opcode = pva_pkg::OP_NOTE_ON;
        else if (pick < 55)
        begin
            ev.opcode = pva_pkg::OP_NOTE_OFF;
            v = pick_voice(pva_pkg::ST_ACTIVE);
            if (v >= 0 && $urandom_range(0, 4) != 0)
            begin
                ev.note    = tbl_note[v];
                ev.channel = tbl_channel[v];
            end
        end
        else if (pick < 58)
            ev.opcode = pva_pkg::OP_REL_ALL;
        else if (pick < 72)
        begin
            ev.opcode = pva_pkg::OP_LEVEL;
            v = pick_voice(pva_pkg::ST_ACTIVE);
            if (v >= 0)
                ev.voice_sel = v[3:0];
            if ($urandom_range(0, 3) == 0)
                ev.level = 16'($urandom_range(0, 3));
        end
        else if (pick < 84)
        begin
            ev.opcode = pva_pkg::OP_FINISH;
            v = pick_voice(pva_pkg::ST_RELEASING);
            if (v >= 0)
                ev.voice_sel = v[3:0];
        end
        else if (pick < 95)
            ev.opcode = pva_pkg::OP_ADVANCE;
        else
            ev.opcode = 3'($urandom_range(0, 7));
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Sender: hold start and the request until the block takes the beat.
    // Entered and left at a falling edge; start stays high on return so a
    // back-to-back beat never toggles it within one step.
    // ------------------------------------------------------------------
    task automatic send_event(pva_pkg::request_t ev);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= ev;
        do
            @(posedge clk);
        while (busy);
        pending_reports.push_back(allocate_event(ev));
        events_sent++;
        @(negedge clk);
    endtask

    // Drop start and wait until every owed beat is in, then settle a while.
    task automatic wait_for_reports(int settle);
        int waited;
        start <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending_reports.size() > 0 && waited < DRAIN_CYCLES);
        if (pending_reports.size() > 0)
        begin
            $display("%0t: %0d result beat(s) never arrived", $time, pending_reports.size());
            fail_count++;
            pending_reports.delete();
        end
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_register(logic [pva_pkg::REG_IDX_W-1:0] idx,
                                  logic [pva_pkg::REG_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == pva_pkg::REG_VOICE_LIMIT)
            voices_in_use = value;
        else
            steal_rule = value[1:0];
        reg_writes++;
    endtask

    // Both registers; the unused upper bits of the steal rule get random junk
    task automatic configure(logic [pva_pkg::REG_W-1:0] voices, logic [1:0] rule);
        write_register(pva_pkg::REG_VOICE_LIMIT, voices);
        write_register(pva_pkg::REG_STEAL_RULE, {3'($urandom_range(0, 7)), rule});
    endtask

    // ------------------------------------------------------------------
    // Checker: every done beat must match the oldest owed beat.
    // ------------------------------------------------------------------
    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_reports
        pva_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result beat with nothing owed, expected none, actual %h",
                         $time, result);
                fail_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("voice_index", want.voice_index, result.voice_index);
                compare_field("stole", want.stole, result.stole);
                compare_field("legato", want.legato, result.legato);
                compare_field("changed_mask", want.changed_mask, result.changed_mask);
                compare_field("active_mask", want.active_mask, result.active_mask);
                reports_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every opcode at least once at reset settings (16 voices, oldest), with field extremes.
    task automatic test_event_basics();
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON,
                              7'd127, 7'd127, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF));
        send_event(make_event(pva_pkg::OP_LEVEL, 7'd0, 7'd0, 4'd0, 4'd1, 16'hFFFF, 16'h0000));
        // A level update lands even on an idle voice
        send_event(make_event(pva_pkg::OP_LEVEL,
                              7'd127, 7'd127, 4'd15, 4'd15, 16'h0000, 16'hFFFF));
        send_event(make_event(pva_pkg::OP_ADVANCE, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'hFFFF));
        send_event(make_event(pva_pkg::OP_ADVANCE,
                              7'd127, 7'd127, 4'd15, 4'd15, 16'hFFFF, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd64, 7'd1, 4'd15, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_OFF,
                              7'd127, 7'd0, 4'd15, 4'd0, 16'h0000, 16'h0000));
        // Right note, wrong channel: nothing releases
        send_event(make_event(pva_pkg::OP_NOTE_OFF, 7'd64, 7'd0, 4'd3, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_REL_ALL, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        // Already releasing voices stay put
        send_event(make_event(pva_pkg::OP_REL_ALL, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_FINISH, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_FINISH, 7'd0, 7'd0, 4'd0, 4'd5, 16'h0000, 16'h0000));
        send_event(make_event(OP_SPARE_A, 7'd127, 7'd127, 4'd15, 4'd15, 16'hFFFF, 16'hFFFF));
        send_event(make_event(OP_SPARE_B, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd60, 7'd90, 4'd2, 4'd0, 16'h0000, 16'h0000));
        wait_for_reports(4);
    endtask

    // One voice: a held voice only takes new pitch and velocity; a releasing one gets stolen.
    task automatic test_mono_legato();
        configure(5'd1, pva_pkg::STEAL_OLDEST);
        send_event(make_event(pva_pkg::OP_NOTE_ON,
                              7'd62, 7'd100, 4'd9, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd65, 7'd20, 4'd9, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_REL_ALL, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd67, 7'd70, 4'd4, 4'd0, 16'h0000, 16'h0000));
        wait_for_reports(4);
    endtask

    // Two voices, both sounding: steal by pitch, then by level.
    task automatic test_steal_choice();
        configure(5'd2, pva_pkg::STEAL_HIGHEST);
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd40, 7'd50, 4'd1, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd30, 7'd50, 4'd1, 4'd0, 16'h0000, 16'h0000));
        wait_for_reports(4);
        configure(5'd2, pva_pkg::STEAL_QUIETEST);
        send_event(make_event(pva_pkg::OP_LEVEL, 7'd0, 7'd0, 4'd0, 4'd0, 16'h8000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd50, 7'd50, 4'd1, 4'd0, 16'h0000, 16'h0000));
        wait_for_reports(4);
    endtask

    // Random traffic over a series of register settings, extremes among them.
    task automatic test_random_traffic();
        logic [pva_pkg::REG_W-1:0] voice_plan [PHASES];
        voice_plan = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd0, 5'd2, 5'd17, 5'd8,
                       5'd3, 5'd16, 5'd1, 5'd5};
        for (int p = 0; p < PHASES; p++)
        begin
            // Sender idles lightly, then heavily, then not at all
            sender_idle_pct = (p < 4) ? 8 : ((p < 8) ? 49 : 0);
            wait_for_reports(4);
            configure(voice_plan[p], 2'((p + p / 4) % 4));
            for (int k = 0; k < RANDOM_EVENTS / PHASES; k++)
            begin
                send_event(random_event());
                // Hold off until the block has answered everything
                if (k == 60 || $urandom_range(0, 199) == 0)
                    wait_for_reports(0);
            end
        end
        wait_for_reports(4);
    endtask

    // Start times follow the sample counter: the earlier voice is stolen
    // first, and voices started at the same count tie to the lower index.
    task automatic test_start_time_order();
        sender_idle_pct = 0;
        configure(5'd2, pva_pkg::STEAL_OLDEST);
        send_event(make_event(pva_pkg::OP_FINISH, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_FINISH, 7'd0, 7'd0, 4'd0, 4'd1, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd70, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_ADVANCE, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'hFFFF));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd71, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_ADVANCE, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'hFFFF));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd72, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd73, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        // Both voices restarted without a time step: equal start times
        send_event(make_event(pva_pkg::OP_FINISH, 7'd0, 7'd0, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_FINISH, 7'd0, 7'd0, 4'd0, 4'd1, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd74, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd75, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        send_event(make_event(pva_pkg::OP_NOTE_ON, 7'd76, 7'd60, 4'd0, 4'd0, 16'h0000, 16'h0000));
        wait_for_reports(4);
    endtask

    initial
    begin
        clear_voice_table();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_event_basics();
        test_mono_legato();
        test_steal_choice();
        test_random_traffic();
        test_start_time_order();

        // Let any straggler beat show up before judging
        wait_for_reports(pva_pkg::VOICES + 4);

        $display("Sent %0d events and checked %0d result beats over %0d register writes,",
                 events_sent, reports_checked, reg_writes);
        $display("covering all steal rules, voice counts 0 to 31, mono legato and start-time ties.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== poly_voice_allocator.f =====
hdl/pva_pkg.sv
hdl/pva_cell.sv
hdl/poly_voice_allocator.sv
tb/poly_voice_allocator_test.sv
